/* rtl/core/enode_pkg.sv */
// ----------------------------------------------------------------------------
// enode_pkg
// Shared types and constants for the extent node search block.
// ----------------------------------------------------------------------------
package enode_pkg;

  localparam int unsigned MagicW  = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned LogW    = 32;
  localparam int unsigned BlockW  = 48;
  localparam int unsigned StatusW = 3;
  localparam int unsigned InDataW = 176;

  localparam logic [MagicW-1:0] MagicReset = 16'hF30A;
  localparam logic [15:0]       LenMask    = 16'h7FFF;

  localparam logic ActHeader = 1'b0;
  localparam logic ActEntry  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_MAPPED    = 3'd0,
    ST_DESCEND   = 3'd1,
    ST_HOLE      = 3'd2,
    ST_NO_INDEX  = 3'd3,
    ST_BAD_MAGIC = 3'd4
  } status_t;

  typedef struct packed {
    logic [CountW-1:0] entries_left;
    logic              leaf_mode;
    logic [LogW-1:0]   sought_block;
    logic              match_found;
    logic [LogW-1:0]   best_start;
    logic [BlockW-1:0] best_block;
  } node_state_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [BlockW-1:0] block;
  } result_t;

  typedef struct packed {
    logic [LogW-1:0]   last_word;
    logic [LogW-1:0]   middle_word;
    logic [LogW-1:0]   first_logical;
    logic [15:0]       node_depth;
    logic [CountW-1:0] entry_count;
    logic [MagicW-1:0] header_magic;
    logic [LogW-1:0]   target_block;
  } item_data_t;

endpackage

/* rtl/core/enode_eval.sv */
// ----------------------------------------------------------------------------
// enode_eval
// Evaluates one header or entry request against the node state and gives the
// next state and, when the node's verdict is known, a result.
// ----------------------------------------------------------------------------
module enode_eval (
  input  logic                              action,
  input  enode_pkg::item_data_t             item,
  input  logic [enode_pkg::MagicW-1:0]      node_magic,
  input  enode_pkg::node_state_t            state,
  output enode_pkg::node_state_t            state_next,
  output enode_pkg::result_t                result
);

  logic [enode_pkg::LogW:0]     extent_end;
  logic [enode_pkg::LogW-1:0]   offset;
  logic [enode_pkg::BlockW-1:0] phys_start;
  logic [enode_pkg::BlockW-1:0] phys_block;
  logic                         leaf_hit;
  logic                         index_hit;
  logic                         last_entry;

  assign extent_end = {1'b0, item.first_logical}
                    + {17'd0, item.middle_word[15:0] & enode_pkg::LenMask};
  assign offset     = state.sought_block - item.first_logical;
  assign phys_start = {item.middle_word[31:16], item.last_word};
  assign phys_block = phys_start + {16'd0, offset};
  assign leaf_hit   = !state.match_found
                   && (state.sought_block >= item.first_logical)
                   && ({1'b0, state.sought_block} < extent_end);
  assign index_hit  = (item.first_logical <= state.sought_block)
                   && (!state.match_found || (item.first_logical > state.best_start));
  assign last_entry = (state.entries_left == 16'd1);

  always_comb begin
    state_next    = state;
    result.valid  = 1'b0;
    result.status = enode_pkg::ST_MAPPED;
    result.block  = '0;
    if (action == enode_pkg::ActHeader) begin
      state_next.sought_block = item.target_block;
      state_next.leaf_mode    = (item.node_depth == 16'd0);
      state_next.match_found  = 1'b0;
      state_next.best_start   = '0;
      state_next.best_block   = '0;
      state_next.entries_left = item.entry_count;
      if (item.header_magic != node_magic) begin
        state_next.entries_left = '0;
        result.valid            = 1'b1;
        result.status           = enode_pkg::ST_BAD_MAGIC;
      end else if (item.entry_count == 16'd0) begin
        result.valid  = 1'b1;
        result.status = (item.node_depth == 16'd0) ? enode_pkg::ST_HOLE
                                                   : enode_pkg::ST_NO_INDEX;
      end
    end else if (state.entries_left != 16'd0) begin
      state_next.entries_left = state.entries_left - 16'd1;
      if (state.leaf_mode) begin
        if (leaf_hit) begin
          state_next.best_block  = phys_block;
          state_next.best_start  = item.first_logical;
          state_next.match_found = 1'b1;
        end
      end else if (index_hit) begin
        state_next.best_start  = item.first_logical;
        state_next.best_block  = {item.last_word[15:0], item.middle_word};
        state_next.match_found = 1'b1;
      end
      if (last_entry) begin
        result.valid = 1'b1;
        if (state_next.match_found) begin
          result.status = state.leaf_mode ? enode_pkg::ST_MAPPED : enode_pkg::ST_DESCEND;
          result.block  = state_next.best_block;
        end else begin
          result.status = state.leaf_mode ? enode_pkg::ST_HOLE : enode_pkg::ST_NO_INDEX;
        end
      end
    end
  end

endmodule

/* rtl/core/extent_node_search.sv */
// A settling request (a bad or empty header, or a node's last entry) puts its
// result in the output register, or in the skid register behind a waiting
// result. One request per cycle is taken while the skid register is empty;
// the two-entry buffer keeps the slave side open while one result waits.
// Reset clears the node state and buffer and loads the expected magic 0xF30A.
// ----------------------------------------------------------------------------
// extent_node_search
// Searches one extent-tree node, streamed as a header and its entries, for a
// logical block and reports the mapping, child node or failure.
// ----------------------------------------------------------------------------
module extent_node_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [enode_pkg::MagicW-1:0]     cfg_wdata,     // node_magic
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // target_block, header_magic, entry_count, node_depth, first_logical,
  // middle_word, last_word
  input  logic [enode_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                             s_axis_tuser,  // action
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [enode_pkg::BlockW-1:0]     m_axis_tdata,  // block
  output logic [enode_pkg::StatusW-1:0]    m_axis_tuser   // status
);

  logic [enode_pkg::MagicW-1:0] node_magic;
  enode_pkg::node_state_t       state;
  enode_pkg::node_state_t       state_next;
  enode_pkg::result_t           result;
  enode_pkg::item_data_t        item;
  logic                         out_valid;
  enode_pkg::status_t           out_status;
  logic [enode_pkg::BlockW-1:0] out_block;
  logic                         skid_valid;
  enode_pkg::status_t           skid_status;
  logic [enode_pkg::BlockW-1:0] skid_block;
  logic                         accept;
  logic                         push;
  logic                         pop;

  assign item          = enode_pkg::item_data_t'(s_axis_tdata);
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && result.valid;
  assign pop           = out_valid && m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_block;
  assign m_axis_tuser  = out_status;

  enode_eval u_eval (
    .action     (s_axis_tuser),
    .item       (item),
    .node_magic (node_magic),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_magic <= enode_pkg::MagicReset;
    end else if (cfg_wen) begin
      node_magic <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_status  <= skid_status;
        out_block   <= skid_block;
        skid_status <= result.status;
        skid_block  <= result.block;
      end else begin
        out_status <= result.status;
        out_block  <= result.block;
      end
    end else if (push) begin
      skid_status <= result.status;
      skid_block  <= result.block;
    end
  end

endmodule

/* rtl/core/enode_checker.sv */
// ----------------------------------------------------------------------------
// enode_checker
// Port-level checks for the extent node search block.
// ----------------------------------------------------------------------------
module enode_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [enode_pkg::InDataW-1:0]    s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [enode_pkg::BlockW-1:0]     m_axis_tdata,
  input logic [enode_pkg::StatusW-1:0]    m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Result valid right after reset.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= enode_pkg::ST_BAD_MAGIC))
    else $error("Result status out of range.");

  a_fail_block_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == enode_pkg::ST_HOLE
                       || m_axis_tuser == enode_pkg::ST_NO_INDEX
                       || m_axis_tuser == enode_pkg::ST_BAD_MAGIC))
      |-> (m_axis_tdata == '0))
    else $error("Failure result carries a nonzero block.");

  a_empty_header_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == enode_pkg::ActHeader)
     && (s_axis_tdata[63:48] == 16'd0)) |=> m_axis_tvalid)
    else $error("Empty or bad header gave no result.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("Stalled result changed.");

endmodule

bind extent_node_search enode_checker u_enode_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
